FILE: rtl/lsrg_pkg.sv
package lsrg_pkg;

  localparam int unsigned AXIS_W     = 2;
  localparam int unsigned CFG_DATA_W = 31;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned COEF_W     = 31;
  localparam int unsigned DIAG_W     = COEF_W + 3;
  localparam int unsigned VALUE_W    = 36;
  localparam int unsigned NBR_N      = 6;

  localparam logic [AXIS_W-1:0]  AXES_RST = 2'd3;
  localparam logic [COEF_W-1:0]  COEF_RST = 31'd65536;
  localparam logic [VALUE_W-1:0] ONE_Q16  = 36'd65536;

  // neighbour slots, emitted in this order
  localparam int unsigned NBR_XM = 0;
  localparam int unsigned NBR_XP = 1;
  localparam int unsigned NBR_YM = 2;
  localparam int unsigned NBR_YP = 3;
  localparam int unsigned NBR_ZM = 4;
  localparam int unsigned NBR_ZP = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AXIS_COUNT = 3'd0,
    REG_SIZE_X     = 3'd1,
    REG_SIZE_Y     = 3'd2,
    REG_SIZE_Z     = 3'd3,
    REG_COEF_X     = 3'd4,
    REG_COEF_Y     = 3'd5,
    REG_COEF_Z     = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic              boundary;
    logic [NBR_N-1:0]  nbr;
    logic [DIAG_W-1:0] diag;
  } row_ctrl_t;

  localparam int unsigned ROW_CTRL_W = $bits(row_ctrl_t);

endpackage

FILE: rtl/lsrg_if.sv
interface lsrg_pnt_if #(
  parameter int unsigned COORD_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;
  logic [COORD_BITS-1:0] point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface lsrg_ent_if #(
  parameter int unsigned COORD_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] column_x;
  logic [COORD_BITS-1:0] column_y;
  logic [COORD_BITS-1:0] column_z;
  logic signed [35:0]    entry_value;
  logic                  last_entry;

  modport source (output valid, column_x, column_y, column_z, entry_value, last_entry,
                  input ready);
  modport sink   (input valid, column_x, column_y, column_z, entry_value, last_entry,
                  output ready);
endinterface

FILE: rtl/lsrg_front.sv
module lsrg_front
  import lsrg_pkg::*;
#(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [COORD_BITS-1:0] point_x_i,
  input  logic [COORD_BITS-1:0] point_y_i,
  input  logic [COORD_BITS-1:0] point_z_i,
  input  logic [AXIS_W-1:0]     axis_count_i,
  input  logic [COORD_BITS:0]   size_x_i,
  input  logic [COORD_BITS:0]   size_y_i,
  input  logic [COORD_BITS:0]   size_z_i,
  input  logic [COEF_W-1:0]     coef_x_i,
  input  logic [COEF_W-1:0]     coef_y_i,
  input  logic [COEF_W-1:0]     coef_z_i,
  output logic                  push_valid_o,
  input  logic                  push_ready_i,
  output logic [COORD_BITS-1:0] row_x_o,
  output logic [COORD_BITS-1:0] row_y_o,
  output logic [COORD_BITS-1:0] row_z_o,
  output row_ctrl_t             row_ctrl_o
);

  localparam int unsigned EW = COORD_BITS + 2;

  function automatic logic on_edge(logic [COORD_BITS-1:0] p, logic [COORD_BITS:0] s);
    logic [EW-1:0] lim;
    lim = {1'b0, s} - EW'(1);
    return (p == '0) || ({2'b00, p} == lim);
  endfunction

  function automatic logic lo_ok(logic [COORD_BITS-1:0] p);
    return p > COORD_BITS'(1);
  endfunction

  function automatic logic hi_ok(logic [COORD_BITS-1:0] p, logic [COORD_BITS:0] s);
    return ({2'b00, p} + EW'(2)) < {1'b0, s};
  endfunction

  logic                  ax2, ax3;
  logic [COORD_BITS-1:0] px, py, pz;
  logic [COEF_W-1:0]     cy, cz;
  logic [COEF_W+1:0]     coef_sum;
  row_ctrl_t             ctrl;

  logic                  valid_q, valid_d;
  logic [COORD_BITS-1:0] x_q, y_q, z_q;
  row_ctrl_t             ctrl_q;
  logic                  load;

  // axis count of zero behaves as one axis
  assign ax2 = axis_count_i[1];
  assign ax3 = (axis_count_i == 2'd3);
  assign px  = point_x_i;
  assign py  = ax2 ? point_y_i : '0;
  assign pz  = ax3 ? point_z_i : '0;
  assign cy  = ax2 ? coef_y_i : '0;
  assign cz  = ax3 ? coef_z_i : '0;

  assign coef_sum = {2'b00, coef_x_i} + {2'b00, cy} + {2'b00, cz};

  always_comb begin
    ctrl.boundary     = on_edge(px, size_x_i) | (ax2 & on_edge(py, size_y_i))
                      | (ax3 & on_edge(pz, size_z_i));
    ctrl.nbr          = '0;
    ctrl.nbr[NBR_XM]  = lo_ok(px);
    ctrl.nbr[NBR_XP]  = hi_ok(px, size_x_i);
    ctrl.nbr[NBR_YM]  = ax2 & lo_ok(py);
    ctrl.nbr[NBR_YP]  = ax2 & hi_ok(py, size_y_i);
    ctrl.nbr[NBR_ZM]  = ax3 & lo_ok(pz);
    ctrl.nbr[NBR_ZP]  = ax3 & hi_ok(pz, size_z_i);
    ctrl.diag         = {coef_sum, 1'b0};
  end

  assign in_ready_o = !valid_q || push_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      x_q    <= px;
      y_q    <= py;
      z_q    <= pz;
      ctrl_q <= ctrl;
    end
  end

  assign push_valid_o = valid_q;
  assign row_x_o      = x_q;
  assign row_y_o      = y_q;
  assign row_z_o      = z_q;
  assign row_ctrl_o   = ctrl_q;

endmodule

FILE: rtl/lsrg_fifo.sv
module lsrg_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/lsrg_back.sv
module lsrg_back
  import lsrg_pkg::*;
#(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  pop_valid_i,
  output logic                  pop_ready_o,
  input  logic [COORD_BITS-1:0] row_x_i,
  input  logic [COORD_BITS-1:0] row_y_i,
  input  logic [COORD_BITS-1:0] row_z_i,
  input  row_ctrl_t             row_ctrl_i,
  input  logic [COEF_W-1:0]     coef_x_i,
  input  logic [COEF_W-1:0]     coef_y_i,
  input  logic [COEF_W-1:0]     coef_z_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [COORD_BITS-1:0] column_x_o,
  output logic [COORD_BITS-1:0] column_y_o,
  output logic [COORD_BITS-1:0] column_z_o,
  output logic [VALUE_W-1:0]    entry_value_o,
  output logic                  last_entry_o
);

  logic                  cur_valid_q, cur_valid_d;
  logic                  diag_pend_q, diag_pend_d;
  logic [COORD_BITS-1:0] cx_q, cy_q, cz_q;
  row_ctrl_t             ctrl_q, ctrl_d;

  logic                  ov_q, ov_d;
  logic [COORD_BITS-1:0] ox_q, oy_q, oz_q;
  logic [VALUE_W-1:0]    oval_q;
  logic                  olast_q;

  logic [NBR_N-1:0]      sel, rem_nxt;
  logic [COORD_BITS-1:0] nx, ny, nz;
  logic [VALUE_W-1:0]    nval;
  logic                  nlast;
  logic                  advance, pop;

  // lowest pending neighbour, as a one-hot
  assign sel     = ctrl_q.nbr & (~ctrl_q.nbr + NBR_N'(1));
  assign rem_nxt = ctrl_q.nbr & ~sel;

  always_comb begin
    nx = cx_q;
    ny = cy_q;
    nz = cz_q;
    if (diag_pend_q) begin
      nval  = ctrl_q.boundary ? ONE_Q16 : VALUE_W'(ctrl_q.diag);
      nlast = ctrl_q.boundary || (ctrl_q.nbr == '0);
    end else begin
      nlast = (rem_nxt == '0);
      priority if (sel[NBR_XM]) begin
        nx   = cx_q - COORD_BITS'(1);
        nval = '0 - VALUE_W'(coef_x_i);
      end else if (sel[NBR_XP]) begin
        nx   = cx_q + COORD_BITS'(1);
        nval = '0 - VALUE_W'(coef_x_i);
      end else if (sel[NBR_YM]) begin
        ny   = cy_q - COORD_BITS'(1);
        nval = '0 - VALUE_W'(coef_y_i);
      end else if (sel[NBR_YP]) begin
        ny   = cy_q + COORD_BITS'(1);
        nval = '0 - VALUE_W'(coef_y_i);
      end else if (sel[NBR_ZM]) begin
        nz   = cz_q - COORD_BITS'(1);
        nval = '0 - VALUE_W'(coef_z_i);
      end else begin
        nz   = cz_q + COORD_BITS'(1);
        nval = '0 - VALUE_W'(coef_z_i);
      end
    end
  end

  assign advance     = cur_valid_q && (!ov_q || out_ready_i);
  assign pop_ready_o = !cur_valid_q || (advance && nlast);
  assign pop         = pop_valid_i && pop_ready_o;

  always_comb begin
    cur_valid_d = cur_valid_q;
    diag_pend_d = diag_pend_q;
    ctrl_d      = ctrl_q;
    if (pop) begin
      cur_valid_d = 1'b1;
      diag_pend_d = 1'b1;
      ctrl_d      = row_ctrl_i;
    end else if (advance) begin
      cur_valid_d = !nlast;
      diag_pend_d = 1'b0;
      if (!diag_pend_q) begin
        ctrl_d.nbr = rem_nxt;
      end
    end
  end

  always_comb begin
    ov_d = ov_q;
    if (advance) begin
      ov_d = 1'b1;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      diag_pend_q <= 1'b0;
      ov_q        <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      diag_pend_q <= diag_pend_d;
      ov_q        <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ctrl_q <= ctrl_d;
    if (pop) begin
      cx_q <= row_x_i;
      cy_q <= row_y_i;
      cz_q <= row_z_i;
    end
    if (advance) begin
      ox_q    <= nx;
      oy_q    <= ny;
      oz_q    <= nz;
      oval_q  <= nval;
      olast_q <= nlast;
    end
  end

  assign out_valid_o   = ov_q;
  assign column_x_o    = ox_q;
  assign column_y_o    = oy_q;
  assign column_z_o    = oz_q;
  assign entry_value_o = oval_q;
  assign last_entry_o  = olast_q;

endmodule

FILE: rtl/laplacian_stencil_row_generator_unit.sv
// Laplacian stencil row generator: each point beat yields the entries of its
// matrix row, diagonal first, then x-1, x+1, y-1, y+1, z-1, z+1, one entry beat per
// cycle while the sink is ready, last_entry marking the final one. A boundary point
// yields one entry and an interior point up to seven, all sent by the back-end
// sequencer through a single output register. The front end classifies points
// and computes the diagonal; a two-deep queue lets it run ahead while the sequencer
// works through a row, and a row of one entry follows the previous row with no gap.
// A point passes the front-end register, the queue and the sequencer. Configuration
// writes must only happen while no row is in flight.
module laplacian_stencil_row_generator_unit
  import lsrg_pkg::*;
#(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  lsrg_pnt_if.sink              pnt_i,
  lsrg_ent_if.source            ent_o
);

  localparam int unsigned SIZE_W  = COORD_BITS + 1;
  localparam int unsigned QUEUE_W = 3 * COORD_BITS + ROW_CTRL_W;
  localparam int unsigned QUEUE_D = 2;
  localparam logic [SIZE_W-1:0] SIZE_RST = SIZE_W'(1) << COORD_BITS;

  logic [AXIS_W-1:0] axis_q;
  logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
  logic [COEF_W-1:0] coef_x_q, coef_y_q, coef_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q   <= AXES_RST;
      size_x_q <= SIZE_RST;
      size_y_q <= SIZE_RST;
      size_z_q <= SIZE_RST;
      coef_x_q <= COEF_RST;
      coef_y_q <= COEF_RST;
      coef_z_q <= COEF_RST;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_AXIS_COUNT: axis_q   <= cfg_data_i[AXIS_W-1:0];
        REG_SIZE_X:     size_x_q <= cfg_data_i[SIZE_W-1:0];
        REG_SIZE_Y:     size_y_q <= cfg_data_i[SIZE_W-1:0];
        REG_SIZE_Z:     size_z_q <= cfg_data_i[SIZE_W-1:0];
        REG_COEF_X:     coef_x_q <= cfg_data_i[COEF_W-1:0];
        REG_COEF_Y:     coef_y_q <= cfg_data_i[COEF_W-1:0];
        REG_COEF_Z:     coef_z_q <= cfg_data_i[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  logic                  push_valid, push_ready, pop_valid, pop_ready;
  logic [COORD_BITS-1:0] fx, fy, fz, bx, by, bz;
  row_ctrl_t             fctrl, bctrl;
  logic [QUEUE_W-1:0]    q_in, q_out;
  logic [VALUE_W-1:0]    value;

  lsrg_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (pnt_i.valid),
    .in_ready_o   (pnt_i.ready),
    .point_x_i    (pnt_i.point_x),
    .point_y_i    (pnt_i.point_y),
    .point_z_i    (pnt_i.point_z),
    .axis_count_i (axis_q),
    .size_x_i     (size_x_q),
    .size_y_i     (size_y_q),
    .size_z_i     (size_z_q),
    .coef_x_i     (coef_x_q),
    .coef_y_i     (coef_y_q),
    .coef_z_i     (coef_z_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .row_x_o      (fx),
    .row_y_o      (fy),
    .row_z_o      (fz),
    .row_ctrl_o   (fctrl)
  );

  assign q_in = {fx, fy, fz, fctrl};

  lsrg_fifo #(
    .WIDTH (QUEUE_W),
    .DEPTH (QUEUE_D)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (q_in),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (q_out)
  );

  assign {bx, by, bz, bctrl} = q_out;

  lsrg_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .row_x_i       (bx),
    .row_y_i       (by),
    .row_z_i       (bz),
    .row_ctrl_i    (bctrl),
    .coef_x_i      (coef_x_q),
    .coef_y_i      (coef_y_q),
    .coef_z_i      (coef_z_q),
    .out_valid_o   (ent_o.valid),
    .out_ready_i   (ent_o.ready),
    .column_x_o    (ent_o.column_x),
    .column_y_o    (ent_o.column_y),
    .column_z_o    (ent_o.column_z),
    .entry_value_o (value),
    .last_entry_o  (ent_o.last_entry)
  );

  assign ent_o.entry_value = $signed(value);

endmodule

FILE: rtl/lsrg_checker.sv
module lsrg_checker
  import lsrg_pkg::*;
#(
  parameter int unsigned COORD_BITS = 10
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [COORD_BITS-1:0]     column_x_i,
  input logic [COORD_BITS-1:0]     column_y_i,
  input logic [COORD_BITS-1:0]     column_z_i,
  input logic signed [VALUE_W-1:0] entry_value_i,
  input logic                      last_entry_i
);

  logic       in_acc, out_acc;
  logic       open_q, open_d;
  logic [3:0] rows_q, rows_d;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_comb begin
    open_d = open_q;
    if (out_acc) begin
      open_d = !last_entry_i;
    end
    rows_d = rows_q + 4'(in_acc) - 4'(out_acc && last_entry_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      rows_q <= '0;
    end else begin
      open_q <= open_d;
      rows_q <= rows_d;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(column_x_i) && $stable(column_y_i)
      && $stable(column_z_i) && $stable(entry_value_i) && $stable(last_entry_i))
    else $error("entry beat changed while stalled");

  // every row opens with its diagonal, which is never negative
  a_diag_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !open_q |-> !entry_value_i[VALUE_W-1])
    else $error("row did not open with a diagonal entry");

  a_nbr_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && open_q |-> entry_value_i[VALUE_W-1] || (entry_value_i == '0))
    else $error("neighbour entry with positive value");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> rows_q != '0)
    else $error("entry beat without a pending point");

  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("entry beat straight out of reset");

endmodule

bind laplacian_stencil_row_generator_unit lsrg_checker #(
  .COORD_BITS (COORD_BITS)
) u_lsrg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (pnt_i.valid),
  .in_ready_i    (pnt_i.ready),
  .out_valid_i   (ent_o.valid),
  .out_ready_i   (ent_o.ready),
  .column_x_i    (ent_o.column_x),
  .column_y_i    (ent_o.column_y),
  .column_z_i    (ent_o.column_z),
  .entry_value_i (ent_o.entry_value),
  .last_entry_i  (ent_o.last_entry)
);

FILE: tb/lsrg_row_checker.sv
`timescale 1ns / 100ps

module lsrg_row_checker
  import lsrg_pkg::*;
#(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  lsrg_pnt_if                   pnt_mon,
  lsrg_ent_if                   ent_mon,
  output int                    mismatches_o,
  output int                    pending_o,
  output int                    rows_o,
  output int                    entries_o
);

  typedef struct packed {
    logic [COORD_BITS-1:0] col_x;
    logic [COORD_BITS-1:0] col_y;
    logic [COORD_BITS-1:0] col_z;
    logic signed [35:0]    value;
    logic                  last;
  } matrix_entry_t;

  matrix_entry_t row_entries_q[$];

  logic [AXIS_W-1:0] axes_q;
  logic [10:0]       size_x_q, size_y_q, size_z_q;
  logic [COEF_W-1:0] coef_x_q, coef_y_q, coef_z_q;

  function automatic bit on_face(int p, int size);
    return (p == 0) || (p == size - 1);
  endfunction

  function automatic matrix_entry_t make_entry(int x, int y, int z, longint v, bit last);
    matrix_entry_t e;
    e.col_x = x[COORD_BITS-1:0];
    e.col_y = y[COORD_BITS-1:0];
    e.col_z = z[COORD_BITS-1:0];
    e.value = v[35:0];
    e.last  = last;
    return e;
  endfunction

  // pushes the whole row for one point: diagonal, then x-1 .. z+1 minus boundary neighbours
  task automatic build_row(input logic [COORD_BITS-1:0] x, y, z);
    int            axes, px, py, pz, sx, sy, sz;
    longint        cx, cy, cz;
    bit            face;
    matrix_entry_t nbrs[$];
    axes = (axes_q == 0) ? 1 : int'(axes_q);
    px   = int'(x);
    py   = (axes >= 2) ? int'(y) : 0;
    pz   = (axes >= 3) ? int'(z) : 0;
    sx   = int'(size_x_q);
    sy   = int'(size_y_q);
    sz   = int'(size_z_q);
    cx   = longint'(coef_x_q);
    cy   = (axes >= 2) ? longint'(coef_y_q) : 0;
    cz   = (axes >= 3) ? longint'(coef_z_q) : 0;
    face = on_face(px, sx) || (axes >= 2 && on_face(py, sy)) || (axes >= 3 && on_face(pz, sz));
    if (face) begin
      row_entries_q.push_back(make_entry(px, py, pz, longint'(65536), 1'b1));
    end else begin
      if (px - 1 > 0)      nbrs.push_back(make_entry(px - 1, py, pz, -cx, 1'b0));
      if (px + 1 < sx - 1) nbrs.push_back(make_entry(px + 1, py, pz, -cx, 1'b0));
      if (axes >= 2) begin
        if (py - 1 > 0)      nbrs.push_back(make_entry(px, py - 1, pz, -cy, 1'b0));
        if (py + 1 < sy - 1) nbrs.push_back(make_entry(px, py + 1, pz, -cy, 1'b0));
      end
      if (axes >= 3) begin
        if (pz - 1 > 0)      nbrs.push_back(make_entry(px, py, pz - 1, -cz, 1'b0));
        if (pz + 1 < sz - 1) nbrs.push_back(make_entry(px, py, pz + 1, -cz, 1'b0));
      end
      row_entries_q.push_back(make_entry(px, py, pz, 2 * (cx + cy + cz), nbrs.size() == 0));
      if (nbrs.size() != 0) nbrs[nbrs.size()-1].last = 1'b1;
      foreach (nbrs[i]) row_entries_q.push_back(nbrs[i]);
    end
  endtask

  task automatic cmp_field(input string what, input longint want, input longint got);
    if (want != got) begin
      mismatches_o++;
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    matrix_entry_t want;
    if (!rst_ni) begin
      axes_q       <= AXES_RST;
      size_x_q     <= 11'd1024;
      size_y_q     <= 11'd1024;
      size_z_q     <= 11'd1024;
      coef_x_q     <= COEF_RST;
      coef_y_q     <= COEF_RST;
      coef_z_q     <= COEF_RST;
      mismatches_o = 0;
      pending_o    <= 0;
      rows_o       = 0;
      entries_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_AXIS_COUNT: axes_q   <= cfg_data_i[AXIS_W-1:0];
          REG_SIZE_X:     size_x_q <= cfg_data_i[10:0];
          REG_SIZE_Y:     size_y_q <= cfg_data_i[10:0];
          REG_SIZE_Z:     size_z_q <= cfg_data_i[10:0];
          REG_COEF_X:     coef_x_q <= cfg_data_i[COEF_W-1:0];
          REG_COEF_Y:     coef_y_q <= cfg_data_i[COEF_W-1:0];
          REG_COEF_Z:     coef_z_q <= cfg_data_i[COEF_W-1:0];
          default: ;
        endcase
      end
      // entry side first, so an entry can never match a point taken at the same edge
      if (ent_mon.valid && ent_mon.ready) begin
        entries_o++;
        if (row_entries_q.size() == 0) begin
          mismatches_o++;
          $display("%0t: entry beat with none expected, actual col (%0d,%0d,%0d) value %0d",
                   $time, ent_mon.column_x, ent_mon.column_y, ent_mon.column_z,
                   ent_mon.entry_value);
        end else begin
          want = row_entries_q.pop_front();
          cmp_field("column_x", longint'(want.col_x), longint'(ent_mon.column_x));
          cmp_field("column_y", longint'(want.col_y), longint'(ent_mon.column_y));
          cmp_field("column_z", longint'(want.col_z), longint'(ent_mon.column_z));
          cmp_field("entry_value", longint'(want.value), longint'(ent_mon.entry_value));
          cmp_field("last_entry", longint'(want.last), longint'(ent_mon.last_entry));
        end
      end
      if (pnt_mon.valid && pnt_mon.ready) begin
        rows_o++;
        build_row(pnt_mon.point_x, pnt_mon.point_y, pnt_mon.point_z);
      end
      pending_o <= row_entries_q.size();
    end
  end

endmodule

FILE: tb/laplacian_stencil_row_generator_unit_tb.sv
`timescale 1ns / 100ps

module laplacian_stencil_row_generator_unit_tb;
  import lsrg_pkg::*;

  localparam int unsigned COORD_BITS     = 10;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam logic [30:0] COEF_MAX       = 31'h7FFF_FFFF;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  lsrg_pnt_if #(.COORD_BITS(COORD_BITS)) pnt ();
  lsrg_ent_if #(.COORD_BITS(COORD_BITS)) ent ();

  int mismatches, pending, rows, entries;
  int idle_cycles;
  int n_settings;
  bit quiet;
  bit hold_req;
  int unsigned cur_sx, cur_sy, cur_sz;

  laplacian_stencil_row_generator_unit #(.COORD_BITS(COORD_BITS)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pnt_i      (pnt),
    .ent_o      (ent)
  );

  lsrg_row_checker #(.COORD_BITS(COORD_BITS)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .pnt_mon      (pnt),
    .ent_mon      (ent),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .rows_o       (rows),
    .entries_o    (entries)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // entry sink: random back-pressure, plus one long hold-off on request
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    ent.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        ent.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
        ent.ready <= 1'b1;
      end else begin
        ent.ready <= quiet || ($urandom_range(0, 99) >= 15);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we || (pnt.valid && pnt.ready) || (ent.valid && ent.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // returns at the edge where the point beat is taken
  task automatic send_point(input logic [COORD_BITS-1:0] x, y, z);
    while (!quiet && $urandom_range(0, 99) < 15) begin
      pnt.valid <= 1'b0;
      @(posedge clk_i);
    end
    pnt.valid   <= 1'b1;
    pnt.point_x <= x;
    pnt.point_y <= y;
    pnt.point_z <= z;
    do @(negedge clk_i); while (!pnt.ready);
    @(posedge clk_i);
  endtask

  task automatic drain();
    pnt.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [30:0] axes, sx, sy, sz, cx, cy, cz);
    drain();
    write_reg(REG_AXIS_COUNT, axes);
    write_reg(REG_SIZE_X, sx);
    write_reg(REG_SIZE_Y, sy);
    write_reg(REG_SIZE_Z, sz);
    write_reg(REG_COEF_X, cx);
    write_reg(REG_COEF_Y, cy);
    write_reg(REG_COEF_Z, cz);
    cfg_we <= 1'b0;
    cur_sx = 32'(sx[10:0]);
    cur_sy = 32'(sy[10:0]);
    cur_sz = 32'(sz[10:0]);
    n_settings++;
  endtask

  // mostly inside the grid, now and then anywhere in the index range
  function automatic logic [COORD_BITS-1:0] pick_coord(int unsigned size);
    if (size < 2 || size > 1024 || $urandom_range(0, 9) == 0) return COORD_BITS'($urandom);
    return COORD_BITS'($urandom_range(0, size - 1));
  endfunction

  initial begin
    logic [30:0] axes, sx, sy, sz, cx, cy, cz;
    rst_ni      <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_idx     <= REG_AXIS_COUNT;
    cfg_data    <= '0;
    pnt.valid   <= 1'b0;
    pnt.point_x <= '0;
    pnt.point_y <= '0;
    pnt.point_z <= '0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    n_settings  = 1;
    cur_sx      = 1024;
    cur_sy      = 1024;
    cur_sz      = 1024;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: corners, points next to the faces, deep interior
    send_point(10'd0, 10'd0, 10'd0);
    send_point(10'd1023, 10'd1023, 10'd1023);
    send_point(10'd1, 10'd1, 10'd1);
    send_point(10'd1022, 10'd1022, 10'd1022);
    send_point(10'd512, 10'd300, 10'd700);
    send_point(10'd1, 10'd1, 10'd5);

    // one axis, smallest grid, junk above the axis field, y/z ignored
    set_config(31'h7FFF_FFFD, 31'd2, 31'd0, 31'd0, COEF_MAX, 31'h1234_5678, 31'h0ABC_DEF0);
    send_point(10'd0, 10'd1023, 10'd1023);
    send_point(10'd1, 10'd5, 10'd5);
    send_point(10'd700, 10'd1023, 10'd512);

    // zero axes behaves as one; size zero
    set_config(31'd0, 31'd0, 31'd5, 31'd5, 31'd65536, COEF_MAX, COEF_MAX);
    send_point(10'd0, 10'd3, 10'd3);
    send_point(10'd1, 10'd3, 10'd3);
    send_point(10'd1023, 10'd0, 10'd0);

    // two axes, size one on x, y wide enough that y+1 wraps the column index
    set_config(31'd2, 31'd1, 31'h7FFF_FFFF, 31'd9, 31'd0, COEF_MAX, COEF_MAX);
    send_point(10'd0, 10'd5, 10'd7);
    send_point(10'd3, 10'd1023, 10'd1023);
    send_point(10'd3, 10'd0, 10'd2);

    // three axes, widest grid, largest coefficients: full row and biggest diagonal
    set_config(31'd3, 31'd2047, 31'd2047, 31'd2047, COEF_MAX, COEF_MAX, COEF_MAX);
    send_point(10'd1023, 10'd1023, 10'd1023);
    send_point(10'd2, 10'd2, 10'd2);
    send_point(10'd0, 10'd5, 10'd5);

    for (int ph = 0; ph < 6; ph++) begin
      axes = 31'($urandom_range(1, 3));
      if (ph == 5) begin
        sx = 31'($urandom_range(2, 1024));
        sy = 31'($urandom_range(2, 1024));
        sz = 31'($urandom_range(2, 1024));
      end else begin
        sx = 31'($urandom_range(2, 12));
        sy = 31'($urandom_range(2, 12));
        sz = 31'($urandom_range(2, 12));
      end
      if (ph % 2 == 1) begin
        cx = 31'($urandom_range(0, 1 << 20));
        cy = 31'($urandom_range(0, 1 << 20));
        cz = 31'($urandom_range(0, 1 << 20));
      end else begin
        cx = 31'($urandom) & COEF_MAX;
        cy = 31'($urandom) & COEF_MAX;
        cz = 31'($urandom) & COEF_MAX;
      end
      set_config(axes, sx, sy, sz, cx, cy, cz);
      quiet = (ph == 3);
      // sink stalls for a long stretch while points keep coming: the block backs up
      if (ph == 1) hold_req = 1'b1;
      repeat (17) send_point(pick_coord(cur_sx), pick_coord(cur_sy), pick_coord(cur_sz));
    end
    quiet = 1'b0;

    drain();
    $display("Covered %0d rows, %0d entry beats over %0d register settings:", rows, entries,
             n_settings);
    $display("1-3 axes, degenerate and wrapping grids, sink hold-off and stall-free stretch.");
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
